[rtl/teaf_pkg.sv]
// Shared types and constants of the triangle edge adjacency finder.
package teaf_pkg;

    localparam int MAX_FACES     = 1024;
    localparam int VERTEX_BITS   = 16;
    localparam int MAX_NEIGHBORS = 16;

    localparam int FACE_AW     = $clog2(MAX_FACES);
    localparam int SCAN_W      = $clog2(MAX_FACES + 1);
    localparam int CNT_W       = $clog2(MAX_NEIGHBORS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int FCOUNT_W    = 11;
    localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = FCOUNT_W'(1);

    localparam logic REG_FACE_COUNT = 1'b0;
    localparam logic FUNC_LOAD      = 1'b0;
    localparam logic FUNC_QUERY     = 1'b1;

    typedef struct packed {
        logic        func;
        logic [9:0]  face_slot;
        logic [15:0] vertex_a;
        logic [15:0] vertex_b;
        logic [15:0] vertex_c;
    } in_item_t;

    typedef struct packed {
        logic [9:0] neighbor_slot;
        logic       found;
        logic       last;
        logic       overflow;
    } out_item_t;

    typedef logic [VERTEX_BITS-1:0] vertex_t;

    typedef struct packed {
        vertex_t c;
        vertex_t b;
        vertex_t a;
    } face_t;

    localparam int FACE_W = $bits(face_t);

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_QUERY,
        CMD_EMPTY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [FACE_AW-1:0] slot;
        face_t              face;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_QCAP,
        BK_SCAN,
        BK_FLUSH
    } back_state_t;

    typedef struct packed {
        logic               wr_en;
        logic [FACE_AW-1:0] wr_addr;
        face_t              wr_data;
        logic               rd_en;
        logic [FACE_AW-1:0] rd_addr;
    } ram_ctrl_t;

    function automatic vertex_t fit_vertex(input logic [15:0] v);
        return VERTEX_BITS'(v);
    endfunction

endpackage

[rtl/teaf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module teaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/teaf_front.sv]
// Input side: accept transfers, classify them and queue commands for the back end.
module teaf_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  teaf_pkg::in_item_t s_data,
    output logic              cmd_valid,
    output teaf_pkg::cmd_t    cmd_head,
    input  logic              cmd_pop
);

    teaf_pkg::cmd_t                 queue_reg [teaf_pkg::QUEUE_DEPTH];
    logic [teaf_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [teaf_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [teaf_pkg::QCNT_W-1:0]    count_reg, count_next;
    teaf_pkg::cmd_t                 new_cmd;
    logic                           push;
    logic                           pop;
    logic                           slot_ok;

    assign s_ready   = (count_reg != teaf_pkg::QCNT_W'(teaf_pkg::QUEUE_DEPTH));
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_head  = queue_reg[rd_ptr_reg];

    assign slot_ok = (32'(s_data.face_slot) < teaf_pkg::MAX_FACES);

    always_comb begin
        new_cmd.slot   = teaf_pkg::FACE_AW'(s_data.face_slot);
        new_cmd.face.a = teaf_pkg::fit_vertex(s_data.vertex_a);
        new_cmd.face.b = teaf_pkg::fit_vertex(s_data.vertex_b);
        new_cmd.face.c = teaf_pkg::fit_vertex(s_data.vertex_c);
        if (s_data.func == teaf_pkg::FUNC_QUERY) begin
            new_cmd.kind = slot_ok ? teaf_pkg::CMD_QUERY : teaf_pkg::CMD_EMPTY;
        end else begin
            new_cmd.kind = teaf_pkg::CMD_LOAD;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == teaf_pkg::QUEUE_DEPTH - 1) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == teaf_pkg::QUEUE_DEPTH - 1) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

[rtl/teaf_back.sv]
// Back end: write loaded faces and scan the face store for each query.
module teaf_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    input  teaf_pkg::cmd_t                  cmd_head,
    output logic                            cmd_pop,
    input  logic [teaf_pkg::SCAN_W-1:0]     limit,
    output teaf_pkg::ram_ctrl_t             ram_ctrl,
    input  teaf_pkg::face_t                 rd_face,
    output logic                            m_valid,
    input  logic                            m_ready,
    output teaf_pkg::out_item_t             m_data
);

    teaf_pkg::back_state_t              state_reg, state_next;
    teaf_pkg::face_t                    qface_reg, qface_next;
    logic [teaf_pkg::SCAN_W-1:0]        limit_reg, limit_next;
    logic [teaf_pkg::SCAN_W-1:0]        scan_reg, scan_next;
    logic                               s1_valid_reg, s1_valid_next;
    logic [teaf_pkg::FACE_AW-1:0]       s1_slot_reg, s1_slot_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic [teaf_pkg::FACE_AW-1:0]       pend_slot_reg, pend_slot_next;
    logic [teaf_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                               out_valid_reg, out_valid_next;
    teaf_pkg::out_item_t                out_data_reg, out_data_next;

    logic       out_free;
    logic [1:0] hit_a, hit_b, hit_c;
    logic       match;
    logic       hold;
    logic       ovf_hit;
    logic       scan_done;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        hit_a = {1'b0, (qface_reg.a == rd_face.a) || (qface_reg.a == rd_face.b)
                       || (qface_reg.a == rd_face.c)};
        hit_b = {1'b0, (qface_reg.b == rd_face.a) || (qface_reg.b == rd_face.b)
                       || (qface_reg.b == rd_face.c)};
        hit_c = {1'b0, (qface_reg.c == rd_face.a) || (qface_reg.c == rd_face.b)
                       || (qface_reg.c == rd_face.c)};
        match = s1_valid_reg && ((hit_a + hit_b + hit_c) == 2'd2);
    end

    assign hold      = match && pend_valid_reg && !out_free;
    assign ovf_hit   = match && pend_valid_reg
                       && (cnt_reg == teaf_pkg::CNT_W'(teaf_pkg::MAX_NEIGHBORS));
    assign scan_done = !s1_valid_reg && (scan_reg == limit_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            teaf_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    case (cmd_head.kind)
                        teaf_pkg::CMD_QUERY: state_next = teaf_pkg::BK_QCAP;
                        teaf_pkg::CMD_EMPTY: state_next = teaf_pkg::BK_FLUSH;
                        default:             state_next = teaf_pkg::BK_IDLE;
                    endcase
                end
            end
            teaf_pkg::BK_QCAP: begin
                state_next = (limit_reg == '0) ? teaf_pkg::BK_FLUSH : teaf_pkg::BK_SCAN;
            end
            teaf_pkg::BK_SCAN: begin
                if (ovf_hit && !hold) begin
                    state_next = teaf_pkg::BK_IDLE;
                end else if (scan_done) begin
                    state_next = teaf_pkg::BK_FLUSH;
                end
            end
            teaf_pkg::BK_FLUSH: begin
                if (out_free) begin
                    state_next = teaf_pkg::BK_IDLE;
                end
            end
            default: state_next = teaf_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        cmd_pop          = 1'b0;
        ram_ctrl.wr_en   = 1'b0;
        ram_ctrl.wr_addr = cmd_head.slot;
        ram_ctrl.wr_data = cmd_head.face;
        ram_ctrl.rd_en   = 1'b0;
        ram_ctrl.rd_addr = cmd_head.slot;
        qface_next       = qface_reg;
        limit_next       = limit_reg;
        scan_next        = scan_reg;
        s1_valid_next    = s1_valid_reg;
        s1_slot_next     = s1_slot_reg;
        pend_valid_next  = pend_valid_reg;
        pend_slot_next   = pend_slot_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_data_next    = out_data_reg;
        case (state_reg)
            teaf_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop         = 1'b1;
                    pend_valid_next = 1'b0;
                    case (cmd_head.kind)
                        teaf_pkg::CMD_LOAD: begin
                            ram_ctrl.wr_en = 1'b1;
                        end
                        teaf_pkg::CMD_QUERY: begin
                            ram_ctrl.rd_en = 1'b1;
                            limit_next     = limit;
                            scan_next      = '0;
                            s1_valid_next  = 1'b0;
                            cnt_next       = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            teaf_pkg::BK_QCAP: begin
                qface_next = rd_face;
            end
            teaf_pkg::BK_SCAN: begin
                if (match && !hold) begin
                    if (pend_valid_reg) begin
                        out_valid_next              = 1'b1;
                        out_data_next.neighbor_slot = 10'(pend_slot_reg);
                        out_data_next.found         = 1'b1;
                        out_data_next.last          = ovf_hit;
                        out_data_next.overflow      = ovf_hit;
                    end
                    if (!ovf_hit) begin
                        pend_valid_next = 1'b1;
                        pend_slot_next  = s1_slot_reg;
                        cnt_next        = cnt_reg + 1'b1;
                    end
                end
                if (!hold && !ovf_hit) begin
                    if (scan_reg < limit_reg) begin
                        ram_ctrl.rd_en   = 1'b1;
                        ram_ctrl.rd_addr = scan_reg[teaf_pkg::FACE_AW-1:0];
                        s1_valid_next    = 1'b1;
                        s1_slot_next     = scan_reg[teaf_pkg::FACE_AW-1:0];
                        scan_next        = scan_reg + 1'b1;
                    end else begin
                        s1_valid_next = 1'b0;
                    end
                end
            end
            teaf_pkg::BK_FLUSH: begin
                if (out_free) begin
                    out_valid_next              = 1'b1;
                    out_data_next.neighbor_slot = pend_valid_reg ? 10'(pend_slot_reg) : '0;
                    out_data_next.found         = pend_valid_reg;
                    out_data_next.last          = 1'b1;
                    out_data_next.overflow      = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= teaf_pkg::BK_IDLE;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            scan_reg       <= '0;
            limit_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            scan_reg       <= scan_next;
            limit_reg      <= limit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        qface_reg     <= qface_next;
        s1_slot_reg   <= s1_slot_next;
        pend_slot_reg <= pend_slot_next;
        out_data_reg  <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[rtl/triangle_edge_adjacency_finder_unit.sv]
// Top level of the triangle edge adjacency finder.
//
//   channel   direction  handshake                 payload
//   s_        in         s_valid / s_ready         teaf_pkg::in_item_t
//   m_        out        m_valid / m_ready         teaf_pkg::out_item_t
//   apb       in         psel/penable/pready       face_count at address 0
//
// A load is a single write to the face memory in the back end. A query scans slots 0 to
// face_count - 1 (face_count capped at the store size) through the single read port of the
// face memory, one slot per cycle unless a stalled result holds the scan; it ends early
// once the neighbor limit is passed. The front queue holds two commands, so input
// transfers continue while the back end scans. A stalled result stalls the scan only
// when a further match needs the output register. Reset sets face_count to 1; the
// face memory is not cleared.
module triangle_edge_adjacency_finder_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  teaf_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output teaf_pkg::out_item_t            m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [teaf_pkg::PADDR_W-1:0]   paddr,
    input  logic [teaf_pkg::PDATA_W-1:0]   pwdata,
    output logic [teaf_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [teaf_pkg::FCOUNT_W-1:0] face_count_reg, face_count_next;
    logic [teaf_pkg::SCAN_W-1:0]   limit;
    logic                          cmd_valid;
    teaf_pkg::cmd_t                cmd_head;
    logic                          cmd_pop;
    teaf_pkg::ram_ctrl_t           ram_ctrl;
    teaf_pkg::face_t               rd_face;
    logic [teaf_pkg::FACE_W-1:0]   rd_bits;

    assign pready = 1'b1;

    always_comb begin
        face_count_next = face_count_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == teaf_pkg::REG_FACE_COUNT)) begin
            face_count_next = pwdata[teaf_pkg::FCOUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_count_reg <= teaf_pkg::FCOUNT_RESET;
        end else begin
            face_count_reg <= face_count_next;
        end
    end

    assign prdata = (paddr[2] == teaf_pkg::REG_FACE_COUNT)
                    ? teaf_pkg::PDATA_W'(face_count_reg) : '0;

    assign limit = (32'(face_count_reg) > teaf_pkg::MAX_FACES)
                   ? teaf_pkg::SCAN_W'(teaf_pkg::MAX_FACES)
                   : teaf_pkg::SCAN_W'(face_count_reg);

    teaf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop)
    );

    teaf_ram #(
        .WIDTH (teaf_pkg::FACE_W),
        .DEPTH (teaf_pkg::MAX_FACES)
    ) u_face_ram (
        .aclk    (aclk),
        .wr_en   (ram_ctrl.wr_en),
        .wr_addr (ram_ctrl.wr_addr),
        .wr_data (ram_ctrl.wr_data),
        .rd_en   (ram_ctrl.rd_en),
        .rd_addr (ram_ctrl.rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_face = rd_bits;

    teaf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .limit     (limit),
        .ram_ctrl  (ram_ctrl),
        .rd_face   (rd_face),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[rtl/teaf_checker.sv]
// Port-level checks of the triangle edge adjacency finder, bound to the top level.
module teaf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input teaf_pkg::out_item_t            m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.last && !m_data.overflow
                                     && (m_data.neighbor_slot == '0))
        else $error("empty answer malformed");

    a_ovf_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |-> m_data.last && m_data.found)
        else $error("overflow on a non-final result");

    a_out_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind triangle_edge_adjacency_finder_unit teaf_checker u_teaf_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for the triangle edge adjacency finder.
module tb_top;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 40;

    typedef enum logic {
        STEP_ITEM,
        STEP_CFG
    } step_kind_t;

    typedef struct {
        step_kind_t          kind;
        teaf_pkg::in_item_t  item;
        bit                  typed;
        teaf_pkg::out_item_t want;
        int unsigned         cfg_value;
    } dir_step_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    teaf_pkg::in_item_t            s_data;
    logic                          m_valid;
    logic                          m_ready;
    teaf_pkg::out_item_t           m_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [teaf_pkg::PADDR_W-1:0]  paddr;
    logic [teaf_pkg::PDATA_W-1:0]  pwdata;
    logic [teaf_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    teaf_pkg::face_t               face_model [teaf_pkg::MAX_FACES];
    logic [teaf_pkg::FCOUNT_W-1:0] face_count_model;
    teaf_pkg::out_item_t           pending_neighbors [$];
    bit                            slot_written [teaf_pkg::MAX_FACES];
    teaf_pkg::vertex_t             vpool [8];
    int unsigned                   pool_size;
    dir_step_t                     dir_steps [$];

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned rx_hold_cycles;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned queries_sent = 0;
    int unsigned results_checked = 0;
    int unsigned overflow_seen = 0;
    int unsigned empty_seen = 0;
    int unsigned cfg_writes = 0;

    triangle_edge_adjacency_finder_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic teaf_pkg::out_item_t result_of(int unsigned slot, bit found,
                                                      bit last, bit ovf);
        teaf_pkg::out_item_t r;
        r.neighbor_slot = 10'(slot);
        r.found         = found;
        r.last          = last;
        r.overflow      = ovf;
        return r;
    endfunction

    function automatic int count_shared(teaf_pkg::face_t p, teaf_pkg::face_t q);
        teaf_pkg::vertex_t pv [3];
        int                n;
        pv[0] = p.a;
        pv[1] = p.b;
        pv[2] = p.c;
        n = 0;
        foreach (pv[i]) begin
            if (pv[i] == q.a || pv[i] == q.b || pv[i] == q.c) begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic void expect_result(teaf_pkg::out_item_t r);
        pending_neighbors.insert(pending_neighbors.size(), r);
    endfunction

    function automatic void predict_neighbors(teaf_pkg::in_item_t it);
        teaf_pkg::face_t     probe;
        teaf_pkg::face_t     loaded;
        teaf_pkg::out_item_t held;
        bit                  have_held;
        bit                  ovf;
        int unsigned         span;
        int unsigned         hits;
        if (it.func == teaf_pkg::FUNC_LOAD) begin
            loaded.a = teaf_pkg::VERTEX_BITS'(it.vertex_a);
            loaded.b = teaf_pkg::VERTEX_BITS'(it.vertex_b);
            loaded.c = teaf_pkg::VERTEX_BITS'(it.vertex_c);
            face_model[it.face_slot] = loaded;
            return;
        end
        span = (face_count_model > teaf_pkg::MAX_FACES) ? teaf_pkg::MAX_FACES
                                                        : face_count_model;
        probe = face_model[it.face_slot];
        hits = 0;
        ovf = 1'b0;
        have_held = 1'b0;
        for (int unsigned j = 0; j < span; j++) begin
            if (count_shared(probe, face_model[j]) == 2) begin
                if (hits == teaf_pkg::MAX_NEIGHBORS) begin
                    ovf = 1'b1;
                    break;
                end
                if (have_held) begin
                    expect_result(held);
                end
                held = result_of(j, 1'b1, 1'b0, 1'b0);
                have_held = 1'b1;
                hits++;
            end
        end
        if (!have_held) begin
            held = result_of(0, 1'b0, 1'b1, 1'b0);
        end
        held.last = 1'b1;
        held.overflow = ovf;
        expect_result(held);
    endfunction

    function automatic teaf_pkg::vertex_t pool_vertex();
        if ($urandom_range(9) == 0) begin
            return teaf_pkg::vertex_t'($urandom);
        end
        return vpool[$urandom_range(pool_size - 1)];
    endfunction

    function automatic void refill_pool(int unsigned size);
        pool_size = size;
        foreach (vpool[i]) begin
            vpool[i] = teaf_pkg::vertex_t'($urandom);
        end
    endfunction

    function automatic teaf_pkg::in_item_t load_item(int unsigned slot);
        teaf_pkg::in_item_t it;
        it.func = teaf_pkg::FUNC_LOAD;
        it.face_slot = 10'(slot);
        it.vertex_a = pool_vertex();
        it.vertex_b = pool_vertex();
        it.vertex_c = pool_vertex();
        slot_written[slot] = 1'b1;
        return it;
    endfunction

    function automatic teaf_pkg::in_item_t query_item(int unsigned slot);
        teaf_pkg::in_item_t it;
        it.func = teaf_pkg::FUNC_QUERY;
        it.face_slot = 10'(slot);
        it.vertex_a = 16'($urandom);
        it.vertex_b = 16'($urandom);
        it.vertex_c = 16'($urandom);
        return it;
    endfunction

    function automatic void add_load(int unsigned slot, logic [15:0] a, logic [15:0] b,
                                     logic [15:0] c);
        dir_step_t st;
        st.kind = STEP_ITEM;
        st.item.func = teaf_pkg::FUNC_LOAD;
        st.item.face_slot = 10'(slot);
        st.item.vertex_a = a;
        st.item.vertex_b = b;
        st.item.vertex_c = c;
        st.typed = 1'b0;
        st.want = '0;
        st.cfg_value = 0;
        slot_written[slot] = 1'b1;
        dir_steps.insert(dir_steps.size(), st);
    endfunction

    function automatic void add_query(int unsigned slot, bit typed,
                                      teaf_pkg::out_item_t want);
        dir_step_t st;
        st.kind = STEP_ITEM;
        st.item = query_item(slot);
        st.typed = typed;
        st.want = want;
        st.cfg_value = 0;
        dir_steps.insert(dir_steps.size(), st);
    endfunction

    function automatic void add_cfg(int unsigned value);
        dir_step_t st;
        st.kind = STEP_CFG;
        st.item = '0;
        st.typed = 1'b0;
        st.want = '0;
        st.cfg_value = value;
        dir_steps.insert(dir_steps.size(), st);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatches < MAX_REPORTS) begin
            $display("tb_top: mismatch at cycle %0d: %s got %0d want %0d",
                     cycle_count, what, got, want);
        end
        mismatches++;
    endtask

    task automatic send_item(teaf_pkg::in_item_t it, bit typed, teaf_pkg::out_item_t want);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        if (typed) begin
            expect_result(want);
        end else begin
            predict_neighbors(it);
        end
        items_sent++;
        if (it.func == teaf_pkg::FUNC_QUERY) begin
            queries_sent++;
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_neighbors.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(bit wr, logic [teaf_pkg::PDATA_W-1:0] wdata,
                              output logic [teaf_pkg::PDATA_W-1:0] rdata);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= teaf_pkg::PADDR_W'(4 * teaf_pkg::REG_FACE_COUNT);
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_face_count_reg();
        logic [teaf_pkg::PDATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== teaf_pkg::PDATA_W'(face_count_model)) begin
            report_mismatch("face_count readback", rd, face_count_model);
        end
    endtask

    task automatic set_face_count(int unsigned value);
        logic [teaf_pkg::PDATA_W-1:0] rd;
        drain_results();
        apb_access(1'b1, teaf_pkg::PDATA_W'(value), rd);
        face_count_model = teaf_pkg::FCOUNT_W'(value);
        cfg_writes++;
        check_face_count_reg();
    endtask

    task automatic fill_prefix(int unsigned n);
        for (int unsigned s = 0; s < n; s++) begin
            if (!slot_written[s]) begin
                send_item(load_item(s), 1'b0, '0);
            end
        end
    endtask

    task automatic run_random(int unsigned count, bit pause_midway);
        int unsigned        n_used;
        int unsigned        slot;
        teaf_pkg::in_item_t it;
        n_used = (face_count_model > teaf_pkg::MAX_FACES) ? teaf_pkg::MAX_FACES
                                                          : face_count_model;
        for (int unsigned i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) begin
                drain_results();
            end
            if ($urandom_range(99) < 40) begin
                slot = ($urandom_range(4) == 0) ? $urandom_range(teaf_pkg::MAX_FACES - 1)
                                                : $urandom_range(n_used - 1);
                it = load_item(slot);
            end else begin
                slot = $urandom_range(teaf_pkg::MAX_FACES - 1);
                if ($urandom_range(4) != 0 || !slot_written[slot]) begin
                    slot = $urandom_range(n_used - 1);
                end
                it = query_item(slot);
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        teaf_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (m_data.overflow) begin
                overflow_seen++;
            end
            if (!m_data.found) begin
                empty_seen++;
            end
            if (pending_neighbors.size() == 0) begin
                report_mismatch("unexpected transfer, neighbor_slot", m_data.neighbor_slot, 0);
            end else begin
                want = pending_neighbors.pop_front();
                if (m_data.neighbor_slot !== want.neighbor_slot) begin
                    report_mismatch("neighbor_slot", m_data.neighbor_slot, want.neighbor_slot);
                end
                if (m_data.found !== want.found) begin
                    report_mismatch("found", m_data.found, want.found);
                end
                if (m_data.last !== want.last) begin
                    report_mismatch("last", m_data.last, want.last);
                end
                if (m_data.overflow !== want.overflow) begin
                    report_mismatch("overflow", m_data.overflow, want.overflow);
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_idle_pct = 22;
        rx_idle_pct = 56;
        rx_hold_cycles = 0;
        face_count_model = teaf_pkg::FCOUNT_RESET;
        refill_pool(8);

        add_load(0, 16'h0001, 16'h0002, 16'h0003);
        add_query(0, 1'b1, result_of(0, 1'b0, 1'b1, 1'b0));
        add_load(teaf_pkg::MAX_FACES - 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_query(teaf_pkg::MAX_FACES - 1, 1'b1, result_of(0, 1'b0, 1'b1, 1'b0));
        add_cfg(0);
        add_query(0, 1'b1, result_of(0, 1'b0, 1'b1, 1'b0));
        add_cfg(2);
        add_load(1, 16'h0001, 16'h0002, 16'hFFFF);
        add_query(0, 1'b1, result_of(1, 1'b1, 1'b1, 1'b0));
        add_query(1, 1'b1, result_of(0, 1'b1, 1'b1, 1'b0));
        // repeated vertex makes the shared count differ by direction
        add_load(1, 16'h0002, 16'h0002, 16'h0001);
        add_query(0, 1'b0, '0);
        add_query(1, 1'b0, '0);
        add_load(teaf_pkg::MAX_FACES - 1, 16'h0003, 16'h0001, 16'h8000);
        add_query(teaf_pkg::MAX_FACES - 1, 1'b0, '0);
        add_load(512, 16'h0000, 16'h0000, 16'h0000);
        add_query(512, 1'b0, '0);
        add_cfg(1);
        add_query(1, 1'b0, '0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        check_face_count_reg();

        foreach (dir_steps[k]) begin
            if (dir_steps[k].kind == STEP_CFG) begin
                set_face_count(dir_steps[k].cfg_value);
            end else begin
                send_item(dir_steps[k].item, dir_steps[k].typed, dir_steps[k].want);
            end
        end

        set_face_count(40);
        fill_prefix(40);
        rx_hold_cycles = 300;
        run_random(90, 1'b1);

        tx_idle_pct = 56;
        rx_idle_pct = 22;
        refill_pool(4);
        set_face_count(24);
        run_random(80, 1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        refill_pool(5);
        fill_prefix(64);
        set_face_count(64);
        send_item(query_item(63), 1'b0, '0);
        repeat (3) send_item(query_item($urandom_range(63)), 1'b0, '0);
        refill_pool(6);
        set_face_count($urandom_range(3, 64));
        run_random(80, 1'b0);

        drain_results();

        $display("tb_top: %0d items sent (%0d queries), %0d face_count writes, %0d cycles",
                 items_sent, queries_sent, cfg_writes, cycle_count);
        $display("tb_top: %0d results checked, %0d empty, %0d overflow, %0d mismatches",
                 results_checked, empty_seen, overflow_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/teaf_pkg.sv
rtl/teaf_ram.sv
rtl/teaf_front.sv
rtl/teaf_back.sv
rtl/triangle_edge_adjacency_finder_unit.sv
rtl/teaf_checker.sv
tb/sv/tb_top.sv
